>>> design/dblf_pkg.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter package
// Shared types, threshold tables and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dblf_pkg;

  typedef logic [7:0] samp_t;

  typedef struct packed {
    logic [2:0] strength;
    logic       is_chroma;
    logic [5:0] qp_avg;
    samp_t      p3;
    samp_t      p2;
    samp_t      p1;
    samp_t      p0;
    samp_t      q0;
    samp_t      q1;
    samp_t      q2;
    samp_t      q3;
  } dblf_line_t;

  typedef struct packed {
    samp_t p2;
    samp_t p1;
    samp_t p0;
    samp_t q0;
    samp_t q1;
    samp_t q2;
    logic  was_filtered;
  } dblf_res_t;

  typedef enum logic {
    CFG_ALPHA_OFFSET = 1'b0,
    CFG_BETA_OFFSET  = 1'b1
  } cfg_idx_t;

  localparam int unsigned QP_LEVELS = 52;
  localparam logic signed [7:0] QP_MAX = 8'sd51;

  localparam samp_t ALPHA_TAB [QP_LEVELS] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,
    8'd12,  8'd13,  8'd15,  8'd17,  8'd20,  8'd22,  8'd25,  8'd28,
    8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd56,  8'd63,  8'd71,
    8'd80,  8'd90,  8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
    8'd203, 8'd226, 8'd255, 8'd255
  };

  localparam logic [4:0] BETA_TAB [QP_LEVELS] = '{
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd3,  5'd4,
    5'd4,  5'd4,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,
    5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
    5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16,
    5'd17, 5'd17, 5'd18, 5'd18
  };

  // Columns are boundary strength 1, 2 and 3.
  localparam logic [4:0] TC0_TAB [QP_LEVELS][3] = '{
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd0},   '{5'd0, 5'd0, 5'd1},
    '{5'd0, 5'd0, 5'd1},   '{5'd0, 5'd0, 5'd1},   '{5'd0, 5'd0, 5'd1},
    '{5'd0, 5'd1, 5'd1},   '{5'd0, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},
    '{5'd1, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},   '{5'd1, 5'd1, 5'd1},
    '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd1, 5'd2},
    '{5'd1, 5'd1, 5'd2},   '{5'd1, 5'd2, 5'd3},   '{5'd1, 5'd2, 5'd3},
    '{5'd2, 5'd2, 5'd3},   '{5'd2, 5'd2, 5'd4},   '{5'd2, 5'd3, 5'd4},
    '{5'd2, 5'd3, 5'd4},   '{5'd3, 5'd3, 5'd5},   '{5'd3, 5'd4, 5'd6},
    '{5'd3, 5'd4, 5'd6},   '{5'd4, 5'd5, 5'd7},   '{5'd4, 5'd5, 5'd8},
    '{5'd4, 5'd6, 5'd9},   '{5'd5, 5'd7, 5'd10},  '{5'd6, 5'd8, 5'd11},
    '{5'd6, 5'd8, 5'd13},  '{5'd7, 5'd10, 5'd14}, '{5'd8, 5'd11, 5'd16},
    '{5'd9, 5'd12, 5'd18}, '{5'd10, 5'd13, 5'd20},'{5'd11, 5'd15, 5'd23},
    '{5'd13, 5'd17, 5'd25}
  };

  // Table index: qp plus a signed offset, clipped to 0..51.
  function automatic logic [5:0] qp_index(input logic [5:0] qp,
                                          input logic signed [4:0] off);
    logic signed [7:0] s;
    s = $signed({2'b00, qp}) + $signed({{3{off[4]}}, off});
    if (s < 8'sd0) begin
      return 6'd0;
    end else if (s > QP_MAX) begin
      return QP_MAX[5:0];
    end else begin
      return s[5:0];
    end
  endfunction

  function automatic samp_t absdiff(input samp_t a, input samp_t b);
    return (a > b) ? samp_t'(a - b) : samp_t'(b - a);
  endfunction

  // Clip a signed value to -t..t.
  function automatic logic signed [11:0] clip_sym(input logic signed [11:0] v,
                                                  input logic [5:0] t);
    logic signed [11:0] lim;
    lim = $signed({6'd0, t});
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end else begin
      return v;
    end
  endfunction

  function automatic samp_t sat8(input logic signed [11:0] v);
    if (v < 12'sd0) begin
      return 8'd0;
    end else if (v > 12'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/dblf_filter.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter datapath
// Threshold lookup, edge decision and normal/strong filter for one line.
// ----------------------------------------------------------------------------
`default_nettype none

module dblf_filter
  import dblf_pkg::*;
(
  input  dblf_line_t        line,
  input  logic signed [4:0] alpha_off,
  input  logic signed [4:0] beta_off,
  output dblf_res_t         res
);

  logic [5:0]  ia;
  logic [5:0]  ib;
  samp_t       alpha;
  samp_t       beta;
  logic [4:0]  tc0;
  logic [5:0]  tc;
  samp_t       ad_p0q0;
  logic        filt_on;
  logic        ap_ok;
  logic        aq_ok;
  logic        strong_sel;
  logic        strong_short;
  samp_t       avg;
  samp_t       p1_tgt;
  samp_t       q1_tgt;
  logic signed [11:0] p1_step;
  logic signed [11:0] q1_step;
  logic signed [11:0] dsum;
  logic signed [11:0] delta;
  samp_t       np1_norm;
  samp_t       nq1_norm;
  samp_t       np0_norm;
  samp_t       nq0_norm;
  samp_t       np0_3tap;
  samp_t       nq0_3tap;
  samp_t       np0_5tap;
  samp_t       np1_4tap;
  samp_t       np2_5tap;
  samp_t       nq0_5tap;
  samp_t       nq1_4tap;
  samp_t       nq2_5tap;

  always_comb begin
    ia      = qp_index(line.qp_avg, alpha_off);
    ib      = qp_index(line.qp_avg, beta_off);
    alpha   = ALPHA_TAB[ia];
    beta    = {3'b000, BETA_TAB[ib]};
    case (line.strength[1:0])
      2'd2:    tc0 = TC0_TAB[ia][1];
      2'd3:    tc0 = TC0_TAB[ia][2];
      default: tc0 = TC0_TAB[ia][0];
    endcase

    ad_p0q0 = absdiff(line.p0, line.q0);
    filt_on = (line.strength != 3'd0) && (ad_p0q0 < alpha) &&
              (absdiff(line.p1, line.p0) < beta) &&
              (absdiff(line.q1, line.q0) < beta);
    ap_ok   = absdiff(line.p2, line.p0) < beta;
    aq_ok   = absdiff(line.q2, line.q0) < beta;
    strong_sel = line.strength[2];

    // Normal filter: luma p1/q1 move toward the averaged target, clipped by tc0.
    avg     = samp_t'((9'(line.p0) + 9'(line.q0) + 9'd1) >> 1);
    p1_tgt  = samp_t'((9'(line.p2) + 9'(avg)) >> 1);
    q1_tgt  = samp_t'((9'(line.q2) + 9'(avg)) >> 1);
    p1_step = clip_sym($signed({4'd0, p1_tgt}) - $signed({4'd0, line.p1}), {1'b0, tc0});
    q1_step = clip_sym($signed({4'd0, q1_tgt}) - $signed({4'd0, line.q1}), {1'b0, tc0});
    // The true sum stays within 0..255, so an 8-bit wrap is exact.
    np1_norm = samp_t'(line.p1 + p1_step[7:0]);
    nq1_norm = samp_t'(line.q1 + q1_step[7:0]);

    if (line.is_chroma) begin
      tc = 6'({1'b0, tc0} + 6'd1);
    end else begin
      tc = 6'({1'b0, tc0} + 6'(ap_ok) + 6'(aq_ok));
    end
    dsum  = (($signed({4'd0, line.q0}) - $signed({4'd0, line.p0})) <<< 2) +
            ($signed({4'd0, line.p1}) - $signed({4'd0, line.q1})) + 12'sd4;
    delta = clip_sym(dsum >>> 3, tc);
    np0_norm = sat8($signed({4'd0, line.p0}) + delta);
    nq0_norm = sat8($signed({4'd0, line.q0}) - delta);

    // Strong filter taps.
    strong_short = line.is_chroma || (ad_p0q0 >= samp_t'((alpha >> 2) + 8'd2));
    np0_3tap = samp_t'((12'({line.p1, 1'b0}) + 12'(line.p0) + 12'(line.q1) + 12'd2) >> 2);
    nq0_3tap = samp_t'((12'({line.q1, 1'b0}) + 12'(line.q0) + 12'(line.p1) + 12'd2) >> 2);
    np0_5tap = samp_t'((12'(line.p2) + 12'({line.p1, 1'b0}) + 12'({line.p0, 1'b0}) +
                        12'({line.q0, 1'b0}) + 12'(line.q1) + 12'd4) >> 3);
    np1_4tap = samp_t'((12'(line.p2) + 12'(line.p1) + 12'(line.p0) + 12'(line.q0) +
                        12'd2) >> 2);
    np2_5tap = samp_t'((12'({line.p3, 1'b0}) + 12'(line.p2) + 12'({line.p2, 1'b0}) +
                        12'(line.p1) + 12'(line.p0) + 12'(line.q0) + 12'd4) >> 3);
    nq0_5tap = samp_t'((12'(line.p1) + 12'({line.p0, 1'b0}) + 12'({line.q0, 1'b0}) +
                        12'({line.q1, 1'b0}) + 12'(line.q2) + 12'd4) >> 3);
    nq1_4tap = samp_t'((12'(line.p0) + 12'(line.q0) + 12'(line.q1) + 12'(line.q2) +
                        12'd2) >> 2);
    nq2_5tap = samp_t'((12'({line.q3, 1'b0}) + 12'(line.q2) + 12'({line.q2, 1'b0}) +
                        12'(line.q1) + 12'(line.q0) + 12'(line.p0) + 12'd4) >> 3);

    // Pass-through by default.
    res.p2 = line.p2;
    res.p1 = line.p1;
    res.p0 = line.p0;
    res.q0 = line.q0;
    res.q1 = line.q1;
    res.q2 = line.q2;
    res.was_filtered = filt_on;

    if (filt_on) begin
      if (!strong_sel) begin
        res.p0 = np0_norm;
        res.q0 = nq0_norm;
        if (!line.is_chroma && ap_ok) begin
          res.p1 = np1_norm;
        end
        if (!line.is_chroma && aq_ok) begin
          res.q1 = nq1_norm;
        end
      end else if (strong_short) begin
        res.p0 = np0_3tap;
        res.q0 = nq0_3tap;
      end else begin
        if (ap_ok) begin
          res.p0 = np0_5tap;
          res.p1 = np1_4tap;
          res.p2 = np2_5tap;
        end else begin
          res.p0 = np0_3tap;
        end
        if (aq_ok) begin
          res.q0 = nq0_5tap;
          res.q1 = nq1_4tap;
          res.q2 = nq2_5tap;
        end else begin
          res.q0 = nq0_3tap;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/deblock_edge_line_filter_top.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter, top level
// Filters one line of eight samples across a block edge per transfer.
// ----------------------------------------------------------------------------
// A line is taken on every clock edge where start is high; busy stays low, so
// one line per cycle is sustained. The result passes an input register, then
// a result register behind the single combinational filter pass, and is
// marked by a one-cycle out_valid strobe; the receiver must take it then, as
// it cannot stall.
// Offsets are written through the cfg_ port (always ready); the user must
// write them only while no line is in flight, as the block does not enforce it.
`default_nettype none

module deblock_edge_line_filter_top
  import dblf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_strength,
  input  wire logic              in_is_chroma,
  input  wire logic [5:0]        in_qp_avg,
  input  wire logic [7:0]        in_p3,
  input  wire logic [7:0]        in_p2,
  input  wire logic [7:0]        in_p1,
  input  wire logic [7:0]        in_p0,
  input  wire logic [7:0]        in_q0,
  input  wire logic [7:0]        in_q1,
  input  wire logic [7:0]        in_q2,
  input  wire logic [7:0]        in_q3,
  output logic                   out_valid,
  output logic [7:0]             out_p2,
  output logic [7:0]             out_p1,
  output logic [7:0]             out_p0,
  output logic [7:0]             out_q0,
  output logic [7:0]             out_q1,
  output logic [7:0]             out_q2,
  output logic                   out_was_filtered,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire cfg_idx_t          cfg_index,
  input  wire logic signed [4:0] cfg_data
);

  logic              in_fire;
  logic              stg_valid_r;
  dblf_line_t        stg_line_r;
  logic              res_valid_r;
  dblf_res_t         res_r;
  dblf_res_t         res_nxt;
  logic signed [4:0] alpha_off_r;
  logic signed [4:0] beta_off_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_off_r <= '0;
      beta_off_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA_OFFSET: alpha_off_r <= cfg_data;
        CFG_BETA_OFFSET:  beta_off_r  <= cfg_data;
        default:          alpha_off_r <= alpha_off_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_fire;
      res_valid_r <= stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_line_r <= '{strength: in_strength, is_chroma: in_is_chroma,
                      qp_avg: in_qp_avg, p3: in_p3, p2: in_p2, p1: in_p1,
                      p0: in_p0, q0: in_q0, q1: in_q1, q2: in_q2, q3: in_q3};
    end
    if (stg_valid_r) begin
      res_r <= res_nxt;
    end
  end

  dblf_filter u_filter (
    .line      (stg_line_r),
    .alpha_off (alpha_off_r),
    .beta_off  (beta_off_r),
    .res       (res_nxt)
  );

  assign out_valid        = res_valid_r;
  assign out_p2           = res_r.p2;
  assign out_p1           = res_r.p1;
  assign out_p0           = res_r.p0;
  assign out_q0           = res_r.q0;
  assign out_q1           = res_r.q1;
  assign out_q2           = res_r.q2;
  assign out_was_filtered = res_r.was_filtered;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ##1 out_valid)
    else $error("accepted line did not produce a result two cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(stg_valid_r))
    else $error("result strobe without a staged line");

  a_zero_bs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_filtered) |-> ($past(stg_line_r.strength) != 3'd0))
    else $error("line with zero strength reported as filtered");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_was_filtered) |->
      (out_p0 == $past(stg_line_r.p0)) && (out_q0 == $past(stg_line_r.q0)) &&
      (out_p1 == $past(stg_line_r.p1)) && (out_q1 == $past(stg_line_r.q1)))
    else $error("unfiltered line changed samples");

  a_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(stg_line_r.is_chroma)) |->
      (out_p1 == $past(stg_line_r.p1)) && (out_q1 == $past(stg_line_r.q1)) &&
      (out_p2 == $past(stg_line_r.p2)) && (out_q2 == $past(stg_line_r.q2)))
    else $error("chroma line changed samples beyond p0 and q0");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == CFG_BETA_OFFSET) |=> (beta_off_r == $past(cfg_data)))
    else $error("beta offset transfer not stored");
`endif

endmodule

`default_nettype wire
